>>> design/jch_pkg.sv
// ----------------------------------------------------------------------------
// Jump consistent hash package
// Constants and types shared by the bucket selector.
// ----------------------------------------------------------------------------
package jch_pkg;

	localparam int unsigned KEY_W    = 64;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned BUCKET_W = 31;
	localparam int unsigned DIV_W    = 32;
	localparam int unsigned STEP_W   = 6;

	localparam logic [KEY_W-1:0] LCG_MULT = 64'd2862933555777941757;
	localparam logic [31:0] LCG_MULT_LO = LCG_MULT[31:0];
	localparam logic [31:0] LCG_MULT_HI = LCG_MULT[63:32];

	localparam int unsigned JUMP_SHIFT = 31;
	localparam int unsigned KEY_SHIFT  = 33;

	localparam logic [STEP_W-1:0] LAST_STEP = '1;

	localparam logic [2:0] ADDR_BUCKET_COUNT = 3'd0;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MUL0  = 6'b000010,
		ST_MUL1  = 6'b000100,
		ST_MUL2  = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_CHECK = 6'b100000
	} state_t;

endpackage

>>> design/jump_consistent_hash_bucket.sv
// Each round updates the 64-bit key through one shared 32x32 multiplier in the states
// ST_MUL0, ST_MUL1 and ST_MUL2, runs a one-bit-per-cycle restoring divider, and then
// compares in ST_CHECK, with about ln(bucket_count) + 1 rounds per item. One item is
// in work at a time and in_ready is low meanwhile, so a new item is taken only after
// the last result has been placed in the output register.
// Reset (arst_n low) sets bucket_count to 1 and empties the output register.
// ----------------------------------------------------------------------------
// Jump consistent hash bucket selector
// Maps a 64-bit key to a bucket index below the bucket count, or 0 for a count of 0.
// ----------------------------------------------------------------------------
module jump_consistent_hash_bucket (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] key,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] bucket
);

	jch_pkg::state_t state_q;

	logic [jch_pkg::COUNT_W-1:0]  count_q;
	logic [jch_pkg::KEY_W-1:0]    key_q;
	logic [jch_pkg::KEY_W-1:0]    acc_q;
	logic [jch_pkg::KEY_W-1:0]    num_q;
	logic [jch_pkg::DIV_W-1:0]    div_q;
	logic [jch_pkg::DIV_W-1:0]    rem_q;
	logic [jch_pkg::COUNT_W-1:0]  cand_q;
	logic [jch_pkg::STEP_W-1:0]   step_q;
	logic [jch_pkg::BUCKET_W-1:0] bucket_q;
	logic                         out_valid_q;

	logic [31:0]                mul_a;
	logic [31:0]                mul_b;
	logic [63:0]                prod;
	logic [63:0]                acc_sum;
	logic [63:0]                key_next;
	logic [32:0]                cand_inc;
	logic [32:0]                rem_sh;
	logic                       rem_ge;
	logic [32:0]                rem_diff;
	logic                       jump_ok;
	logic                       out_free;
	logic                       cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr == jch_pkg::ADDR_BUCKET_COUNT);
	assign prdata   = (paddr == jch_pkg::ADDR_BUCKET_COUNT) ? count_q : 32'd0;

	assign in_ready  = (state_q == jch_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign bucket    = bucket_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		case (state_q)
			jch_pkg::ST_MUL0: begin
				mul_a = key_q[31:0];
				mul_b = jch_pkg::LCG_MULT_LO;
			end
			jch_pkg::ST_MUL1: begin
				mul_a = key_q[31:0];
				mul_b = jch_pkg::LCG_MULT_HI;
			end
			default: begin
				mul_a = key_q[63:32];
				mul_b = jch_pkg::LCG_MULT_LO;
			end
		endcase
	end

	assign prod     = {32'd0, mul_a} * {32'd0, mul_b};
	assign acc_sum  = acc_q + {prod[31:0], 32'd0};
	assign key_next = acc_sum + 64'd1;
	assign cand_inc = {1'b0, cand_q} + 33'd1;

	assign rem_sh   = {rem_q, num_q[63]};
	assign rem_ge   = (rem_sh >= {1'b0, div_q});
	assign rem_diff = rem_sh - {1'b0, div_q};

	assign jump_ok  = (num_q < {32'd0, count_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 32'd1;
		end else if (cfg_wr) begin
			count_q <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == jch_pkg::ST_CHECK) && !jump_ok && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jch_pkg::ST_IDLE;
			step_q      <= '0;
		end else begin
			case (state_q)
				jch_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= jch_pkg::ST_MUL0;
					end
				end
				jch_pkg::ST_MUL0: begin
					state_q <= jch_pkg::ST_MUL1;
				end
				jch_pkg::ST_MUL1: begin
					state_q <= jch_pkg::ST_MUL2;
				end
				jch_pkg::ST_MUL2: begin
					step_q  <= '0;
					state_q <= jch_pkg::ST_DIV;
				end
				jch_pkg::ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == jch_pkg::LAST_STEP) begin
						state_q <= jch_pkg::ST_CHECK;
					end
				end
				jch_pkg::ST_CHECK: begin
					if (jump_ok) begin
						state_q <= jch_pkg::ST_MUL0;
					end else if (out_free) begin
						state_q     <= jch_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= jch_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			jch_pkg::ST_IDLE: begin
				if (in_valid) begin
					key_q  <= key;
					cand_q <= '0;
				end
			end
			jch_pkg::ST_MUL0: begin
				acc_q <= prod;
			end
			jch_pkg::ST_MUL1: begin
				acc_q <= acc_sum;
			end
			jch_pkg::ST_MUL2: begin
				key_q <= key_next;
				div_q <= {1'b0, key_next[63:jch_pkg::KEY_SHIFT]} + 32'd1;
				num_q <= {cand_inc, 31'd0};
				rem_q <= '0;
			end
			jch_pkg::ST_DIV: begin
				rem_q <= rem_ge ? rem_diff[31:0] : rem_sh[31:0];
				num_q <= {num_q[62:0], rem_ge};
			end
			jch_pkg::ST_CHECK: begin
				if (jump_ok) begin
					cand_q <= num_q[31:0];
				end else if (out_free) begin
					bucket_q <= cand_q[30:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> design/jch_checker.sv
// ----------------------------------------------------------------------------
// Jump consistent hash checker
// Port-level assertions for the bucket selector, bound to the top level.
// ----------------------------------------------------------------------------
module jch_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [30:0] bucket
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bucket))
		else $error("A stalled result item changed or was dropped.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("The block took no time to work on an accepted item.");

	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid)
		else $error("The block became ready again without presenting a result item.");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("The configuration port inserted a wait state.");

endmodule

bind jump_consistent_hash_bucket jch_checker u_jch_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.bucket    (bucket)
);

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Jump consistent hash bucket selector testbench
// Programs the bucket count over the register port, streams keys through the
// valid/ready input, and compares every bucket that comes out against a
// bit-exact predictor of the hash. Random gaps on both sides, a long output
// stall and full-rate stretches exercise the handshakes.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [63:0] LCG_STEP_MULT = 64'd2862933555777941757;
	localparam int unsigned JUMP_SCALE    = 31;
	localparam int unsigned KEY_TOP       = 33;
	localparam logic [2:0]  ADDR_SPARE    = 3'd4;
	localparam int unsigned IDLE_PCT      = 13;
	localparam int unsigned CYCLE_LIMIT   = 20_000_000;
	localparam int unsigned TAIL_CYCLES   = 2000;
	localparam int unsigned PRINT_LIMIT   = 100;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [63:0] key       = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [30:0] bucket;

	logic [31:0] count_now = 32'd1;
	logic [30:0] want_buckets[$];
	int unsigned mismatches = 0;
	int unsigned cycles     = 0;
	int unsigned hold_left  = 0;
	bit          steady     = 1'b0;

	jump_consistent_hash_bucket i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.bucket    (bucket)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [30:0] bucket_for_key(input logic [63:0] k,
			input logic [31:0] count);
		logic [63:0] cand;
		logic [63:0] jump;
		logic [63:0] divisor;
		bit          going;
		cand  = '0;
		jump  = '0;
		going = 1'b1;
		while (going) begin
			cand    = jump;
			k       = k * LCG_STEP_MULT + 64'd1;
			divisor = (k >> KEY_TOP) + 64'd1;
			jump    = ((cand + 64'd1) << JUMP_SCALE) / divisor;
			going   = (jump < {32'd0, count});
		end
		return cand[30:0];
	endfunction

	function automatic logic [63:0] rand_key();
		return {$urandom(), $urandom()};
	endfunction

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
		mismatches++;
		if (mismatches <= PRINT_LIMIT) begin
			$display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (want_buckets.size() == 0) begin
					report("bucket with no item waiting", 64'd0, {33'd0, bucket});
				end else begin
					if (bucket !== want_buckets[0]) begin
						report("bucket", {33'd0, want_buckets[0]}, {33'd0, bucket});
					end
					void'(want_buckets.pop_front());
				end
			end
			if (in_valid && in_ready) begin
				want_buckets.push_back(bucket_for_key(key, count_now));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_key(input logic [63:0] k);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		key      <= k;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (want_buckets.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == jch_pkg::ADDR_BUCKET_COUNT) begin
			count_now = data;
		end
	endtask

	task automatic cfg_read(input logic [2:0] addr, output logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		data = prdata;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_count();
		logic [31:0] got;
		cfg_read(jch_pkg::ADDR_BUCKET_COUNT, got);
		if (got !== count_now) begin
			report("bucket_count readback", {32'd0, count_now}, {32'd0, got});
		end
	endtask

	task automatic set_count(input logic [31:0] count);
		drain();
		cfg_write(jch_pkg::ADDR_BUCKET_COUNT, count);
		check_count();
	endtask

	task automatic test_reset_count();
		check_count();
		send_key(64'd0);
		send_key('1);
		send_key(rand_key());
	endtask

	// Counts of zero and one give bucket zero; counts above 2^31 wrap the index.
	task automatic test_edge_counts();
		logic [31:0] counts[5];
		counts = '{32'd0, 32'd1, 32'd2, 32'h8000_0000, 32'hFFFF_FFFF};
		foreach (counts[i]) begin
			set_count(counts[i]);
			send_key(64'd0);
			send_key('1);
			send_key(64'hAAAA_AAAA_AAAA_AAAA);
			send_key(64'h5555_5555_5555_5555);
		end
	endtask

	task automatic test_spare_address();
		set_count(32'd5);
		cfg_write(ADDR_SPARE, 32'd1000);
		check_count();
		send_key(rand_key());
		send_key(rand_key());
	endtask

	task automatic test_random_counts();
		logic [31:0] counts[5];
		int unsigned lengths[5];
		counts  = '{32'd2, 32'd6, 32'($urandom_range(7, 64)), 32'd1000, 32'd65536};
		lengths = '{250, 250, 300, 250, 150};
		foreach (counts[i]) begin
			set_count(counts[i]);
			for (int unsigned n = 0; n < lengths[i]; n++) begin
				if (n == lengths[i] / 2) begin
					drain();
				end
				send_key(rand_key());
			end
		end
	endtask

	task automatic test_back_to_back();
		set_count(32'($urandom_range(3, 40)));
		steady = 1'b1;
		repeat (200) send_key(rand_key());
		drain();
		steady = 1'b0;
	endtask

	task automatic test_output_stall();
		set_count(32'd16);
		hold_left = 3000;
		repeat (30) send_key(rand_key());
		drain();
	endtask

	task automatic test_large_counts();
		logic [31:0] counts[3];
		counts = '{$urandom() | 32'h8000_0000, $urandom_range(32'h0010_0000, 32'h7FFF_FFFF),
			32'h8000_0000};
		foreach (counts[i]) begin
			set_count(counts[i]);
			repeat (10) send_key(rand_key());
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_count();
		test_edge_counts();
		test_spare_address();
		test_random_counts();
		test_back_to_back();
		test_output_stall();
		test_large_counts();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
design/jch_pkg.sv
design/jump_consistent_hash_bucket.sv
design/jch_checker.sv
tb/sv/tb.sv
